// ----- rtl/sgs_pkg.sv -----
package sgs_pkg;

   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_ELEMENT = 2'd1;
   localparam logic [1:0] CMD_READ    = 2'd2;

   localparam logic KIND_ROW  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam int unsigned IDX_W = 10;
   localparam int unsigned VAL_W = 32;
   localparam int unsigned SUM_W = 64;

   typedef struct packed {
      logic [1:0]              command;
      logic [IDX_W-1:0]        index;
      logic [IDX_W-1:0]        row_index;
      logic signed [VAL_W-1:0] element_value;
      logic signed [VAL_W-1:0] rhs_value;
      logic                    first_in_row;
      logic                    last_in_row;
   } req_type;

   typedef struct packed {
      logic                    kind;
      logic [IDX_W-1:0]        out_index;
      logic signed [VAL_W-1:0] out_value;
      logic                    zero_diagonal;
      logic                    saturated;
   } rsp_type;

endpackage

// ----- rtl/sgs_div.sv -----
module sgs_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [sgs_pkg::SUM_W-1:0]         dividend,
   input  logic [sgs_pkg::VAL_W-1:0]         divisor,
   output logic                              done,
   output logic [sgs_pkg::SUM_W-1:0]         quotient
);

   localparam int unsigned CNT_W = $clog2(sgs_pkg::SUM_W) + 1;

   logic                        busy_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [sgs_pkg::VAL_W:0]     rem_ff;
   logic [sgs_pkg::SUM_W-1:0]   quo_ff;
   logic [sgs_pkg::VAL_W-1:0]   div_ff;
   logic [sgs_pkg::VAL_W:0]     rem_sh;
   logic [sgs_pkg::VAL_W+1:0]   trial;

   // one quotient bit per cycle, restoring
   assign rem_sh = {rem_ff[sgs_pkg::VAL_W-1:0], quo_ff[sgs_pkg::SUM_W-1]};
   assign trial  = {1'b0, rem_sh} - {2'b00, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start && (count_ff == CNT_W'(1));
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= CNT_W'(sgs_pkg::SUM_W);
            rem_ff   <= '0;
            quo_ff   <= dividend;
            div_ff   <= divisor;
         end else if (busy_ff) begin
            if (trial[sgs_pkg::VAL_W+1]) begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[sgs_pkg::SUM_W-2:0], 1'b0};
            end else begin
               rem_ff <= trial[sgs_pkg::VAL_W:0];
               quo_ff <= {quo_ff[sgs_pkg::SUM_W-2:0], 1'b1};
            end
            count_ff <= count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/sparse_gauss_seidel_row_sweep.sv -----
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | sgs_pkg::req_type
// rsp     | out       | rsp_valid/rsp_ready  | sgs_pkg::rsp_type
// load: store write on accept; read: store read, then output wait
// non-first row element: store read, multiply, saturating subtract
// last element adds the bit-serial 64/32 divider unless diagonal is zero
// synchronous reset clears control state; solution store is not cleared
// a held result blocks the next read or row result until taken
module sparse_gauss_seidel_row_sweep #(
   parameter int ROWS      = 1024,
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sgs_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sgs_pkg::rsp_type rsp_payload
);

   localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_MUL, S_ACC, S_DIV, S_WAIT, S_OUT
   } state_type;

   state_type                          state_ff;
   logic signed [sgs_pkg::VAL_W-1:0]   mem [ROWS];
   logic signed [sgs_pkg::VAL_W-1:0]   rd_data_ff;
   sgs_pkg::req_type                   item_ff;
   logic                               in_range_ff;
   logic signed [sgs_pkg::SUM_W-1:0]   sum_ff;
   logic signed [sgs_pkg::VAL_W-1:0]   diag_ff;
   logic [sgs_pkg::IDX_W-1:0]          row_ff;
   logic                               clip_ff;
   logic signed [sgs_pkg::SUM_W-1:0]   prod_ff;
   logic                               rsp_valid_ff;
   sgs_pkg::rsp_type                   rsp_ff;

   logic [31:0]                        idx_ext;
   logic [31:0]                        row_ext;
   logic                               accept;
   logic signed [sgs_pkg::SUM_W-1:0]   sum_shr;
   logic                               sum_shr_clip;
   logic signed [sgs_pkg::VAL_W-1:0]   sum_val;
   logic signed [sgs_pkg::VAL_W-1:0]   x_val;
   logic signed [sgs_pkg::SUM_W:0]     diff;
   logic                               div_start;
   logic                               div_done;
   logic [sgs_pkg::SUM_W-1:0]          div_q;
   logic [sgs_pkg::SUM_W-1:0]          sum_abs;
   logic [sgs_pkg::VAL_W-1:0]          diag_abs;
   logic                               q_neg;
   logic                               q_clip;
   logic signed [sgs_pkg::VAL_W-1:0]   result;
   logic                               diag_zero;
   logic                               out_free;
   logic                               rsp_load;

   assign accept   = req_valid && req_ready;
   assign idx_ext  = {22'd0, req_payload.index};
   assign row_ext  = {22'd0, row_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_load = (state_ff == S_READ || state_ff == S_OUT) && out_free;

   assign sum_shr      = sum_ff >>> FRAC_BITS;
   assign sum_shr_clip = (sum_shr[sgs_pkg::SUM_W-1:sgs_pkg::VAL_W-1] != '0) &&
                         (sum_shr[sgs_pkg::SUM_W-1:sgs_pkg::VAL_W-1] != '1);
   assign sum_val = !sum_shr_clip ? sum_shr[sgs_pkg::VAL_W-1:0] :
                    sum_shr[sgs_pkg::SUM_W-1] ? {1'b1, {(sgs_pkg::VAL_W-1){1'b0}}} :
                    {1'b0, {(sgs_pkg::VAL_W-1){1'b1}}};
   assign x_val = (item_ff.index == row_ff) ? sum_val :
                  (in_range_ff ? rd_data_ff : '0);

   assign diff = {sum_ff[sgs_pkg::SUM_W-1], sum_ff} - {prod_ff[sgs_pkg::SUM_W-1], prod_ff};

   assign sum_abs   = sum_ff[sgs_pkg::SUM_W-1] ? ('0 - sum_ff) : sum_ff;
   assign diag_abs  = diag_ff[sgs_pkg::VAL_W-1] ? ('0 - diag_ff) : diag_ff;
   assign diag_zero = (diag_ff == '0);
   assign div_start = (state_ff == S_DIV);
   assign q_neg     = sum_ff[sgs_pkg::SUM_W-1] != diag_ff[sgs_pkg::VAL_W-1];

   always_comb begin
      q_clip = 1'b0;
      result = '0;
      if (diag_zero) begin
         q_clip = 1'b1;
         result = sum_ff[sgs_pkg::SUM_W-1] ? {1'b1, {(sgs_pkg::VAL_W-1){1'b0}}} :
                                             {1'b0, {(sgs_pkg::VAL_W-1){1'b1}}};
      end else if (q_neg) begin
         if (div_q > 64'h0000_0000_8000_0000) begin
            q_clip = 1'b1;
            result = {1'b1, {(sgs_pkg::VAL_W-1){1'b0}}};
         end else begin
            result = '0 - div_q[sgs_pkg::VAL_W-1:0];
         end
      end else begin
         if (div_q > 64'h0000_0000_7FFF_FFFF) begin
            q_clip = 1'b1;
            result = {1'b0, {(sgs_pkg::VAL_W-1){1'b1}}};
         end else begin
            result = div_q[sgs_pkg::VAL_W-1:0];
         end
      end
   end

   sgs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_abs),
      .divisor  (diag_abs),
      .done     (div_done),
      .quotient (div_q)
   );

   // solution store
   always_ff @(posedge clock) begin
      if (accept) begin
         rd_data_ff <= mem[idx_ext[AW-1:0]];
         if (req_payload.command == sgs_pkg::CMD_LOAD && idx_ext < 32'(ROWS)) begin
            mem[idx_ext[AW-1:0]] <= req_payload.element_value;
         end
      end else if (state_ff == S_OUT && out_free && row_ext < 32'(ROWS)) begin
         mem[row_ext[AW-1:0]] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         diag_ff      <= '0;
         row_ff       <= '0;
         clip_ff      <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  item_ff     <= req_payload;
                  in_range_ff <= idx_ext < 32'(ROWS);
                  case (req_payload.command)
                     sgs_pkg::CMD_READ: state_ff <= S_READ;
                     sgs_pkg::CMD_ELEMENT: begin
                        if (req_payload.first_in_row) begin
                           row_ff  <= req_payload.row_index;
                           diag_ff <= req_payload.element_value;
                           sum_ff  <= {{(sgs_pkg::SUM_W-sgs_pkg::VAL_W){
                                        req_payload.rhs_value[sgs_pkg::VAL_W-1]}},
                                       req_payload.rhs_value} <<< FRAC_BITS;
                           clip_ff <= 1'b0;
                           if (req_payload.last_in_row) begin
                              state_ff <= (req_payload.element_value == '0) ? S_OUT : S_DIV;
                           end
                        end else begin
                           state_ff <= S_MUL;
                        end
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_READ: begin
               if (out_free) begin
                  rsp_ff.kind           <= sgs_pkg::KIND_READ;
                  rsp_ff.out_index      <= item_ff.index;
                  rsp_ff.out_value      <= in_range_ff ? rd_data_ff : '0;
                  rsp_ff.zero_diagonal  <= 1'b0;
                  rsp_ff.saturated      <= 1'b0;
                  state_ff              <= S_IDLE;
               end
            end
            S_MUL: begin
               prod_ff <= item_ff.element_value * x_val;
               if (item_ff.index == row_ff && sum_shr_clip) begin
                  clip_ff <= 1'b1;
               end
               state_ff <= S_ACC;
            end
            S_ACC: begin
               if (diff[sgs_pkg::SUM_W] != diff[sgs_pkg::SUM_W-1]) begin
                  clip_ff <= 1'b1;
                  sum_ff  <= diff[sgs_pkg::SUM_W] ? {1'b1, {(sgs_pkg::SUM_W-1){1'b0}}} :
                                                     {1'b0, {(sgs_pkg::SUM_W-1){1'b1}}};
               end else begin
                  sum_ff <= diff[sgs_pkg::SUM_W-1:0];
               end
               if (item_ff.last_in_row) begin
                  state_ff <= diag_zero ? S_OUT : S_DIV;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: state_ff <= S_WAIT;
            S_WAIT: begin
               if (div_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (out_free) begin
                  rsp_ff.kind           <= sgs_pkg::KIND_ROW;
                  rsp_ff.out_index      <= row_ff;
                  rsp_ff.out_value      <= result;
                  rsp_ff.zero_diagonal  <= diag_zero;
                  rsp_ff.saturated      <= q_clip || clip_ff;
                  state_ff              <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- rtl/sgs_chk.sv -----
module sgs_chk (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input sgs_pkg::req_type req_payload,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input sgs_pkg::rsp_type rsp_payload
);

   // stalled transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp changed while stalled");

   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_payload.command == sgs_pkg::CMD_READ |=> !req_ready)
      else $error("ready after read transfer");

   a_read_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.kind == sgs_pkg::KIND_READ |->
         !rsp_payload.zero_diagonal && !rsp_payload.saturated)
      else $error("flags on read data");

   a_zero_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.zero_diagonal |-> rsp_payload.saturated)
      else $error("zero diagonal without saturation");

endmodule

bind sparse_gauss_seidel_row_sweep sgs_chk u_sgs_chk (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_payload (req_payload),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
